// ===== rtl/core/lmti_pkg.sv =====
// Shared types and constants for the multibit trie route insert unit.
package lmti_pkg;

	localparam int GROUP_COUNT       = 256;
	localparam int ENTRIES_PER_GROUP = 256;
	localparam int MAX_PREFIX_LEN    = 32;
	localparam int STRIDE_BITS       = 8;

	// group numbers are 1-based, 0 means no child
	localparam int GRP_W      = $clog2(GROUP_COUNT + 1);
	localparam int GRP_IDX_W  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int NODE_DEPTH = (2 ** GRP_IDX_W) * ENTRIES_PER_GROUP;
	localparam int NODE_AW    = GRP_IDX_W + STRIDE_BITS;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_LEN    = 2'd1,
		ST_POOL_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] route_addr;
		logic [5:0]  prefix_len;
		logic [31:0] hop_value;
	} ins_req_t;

	typedef struct packed {
		status_t     status;
		logic [8:0]  groups_in_use;
	} ins_rsp_t;

	typedef struct packed {
		logic             valid;
		logic [3:0]       depth;
		logic [GRP_W-1:0] child;
		logic [31:0]      hop;
	} node_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEVEL,
		S_CLEAR,
		S_DESC,
		S_EXP,
		S_DRAIN,
		S_FIN
	} ins_state_t;

endpackage

// ===== rtl/core/lmti_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module lmti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/lpm_multibit_trie_insert_unit.sv =====
// Route insert unit: sequencer around one node table RAM, one insert at a time.
// An insert is taken when in_ready is high and answers with exactly one result
// (status, groups in use) through an output register, so a new route can be
// taken while the previous result still waits. A bad prefix length skips the
// trie walk and goes straight to its result. A good one walks each trie level
// through the LEVEL and DESC states, sweeps each new group taken from the pool
// to zero through the single RAM write port before use (so no clearing pass
// follows reset), then expands the 2^(8-r) entries of the last level, r being
// the bits of the prefix that fall in that level (one entry read-modify-write
// per cycle through the RAM's read and write ports), and at last loads the
// result register once the previous result has gone or is being taken. The
// worst case without new groups is a prefix of 25 bits; each new group adds
// its sweep.
module lpm_multibit_trie_insert_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lmti_pkg::ins_req_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output lmti_pkg::ins_rsp_t out_data
);
	import lmti_pkg::*;

	ins_state_t         state_q, state_d;
	logic [31:0]        addr_q;
	logic [5:0]         len_q;
	logic [31:0]        hop_q;
	logic [1:0]         level_q;
	logic [GRP_W-1:0]   child_q;
	logic [GRP_W-1:0]   root_q;
	logic [GRP_W-1:0]   free_q;
	logic [NODE_AW-1:0] parent_addr_q;
	logic [7:0]         k_q;
	logic [7:0]         clr_q;
	status_t            status_q;
	logic               exp_s1;
	logic [NODE_AW-1:0] exp_addr_s1;
	logic               out_valid_q;
	ins_rsp_t           out_q;

	logic               len_bad;
	logic [31:0]        in_mask;
	logic [5:0]         rem;
	logic [3:0]         rem4;
	logic               last_level;
	logic [7:0]         idx;
	logic [GRP_W-1:0]   grp_m1;
	logic [NODE_AW-1:0] base;
	logic [7:0]         exp_last_k;
	logic [GRP_W-1:0]   child_cur;
	logic               pool_full;
	logic [GRP_W-1:0]   free_inc;
	logic               clk_sweep_done;

	logic               ram_wr_en;
	logic [NODE_AW-1:0] ram_wr_addr;
	node_entry_t        ram_wr_data;
	logic               ram_rd_en;
	logic [NODE_AW-1:0] ram_rd_addr;
	logic [$bits(node_entry_t)-1:0] ram_rd_bits;
	node_entry_t        rd_entry;
	node_entry_t        link_entry;

	lmti_ram #(
		.WIDTH($bits(node_entry_t)),
		.DEPTH(NODE_DEPTH)
	) u_node_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_bits)
	);

	assign rd_entry = node_entry_t'(ram_rd_bits);

	assign len_bad = (in_data.prefix_len == 6'd0) ||
		(in_data.prefix_len > 6'(MAX_PREFIX_LEN));
	assign in_mask = 32'hFFFF_FFFF << (6'd32 - in_data.prefix_len);

	assign rem        = len_q - {1'b0, level_q, 3'b000};
	assign rem4       = rem[3:0];
	assign last_level = (rem <= 6'(STRIDE_BITS));
	assign exp_last_k = 8'hFF >> rem4;

	always_comb begin
		case (level_q)
			2'd0:    idx = addr_q[31:24];
			2'd1:    idx = addr_q[23:16];
			2'd2:    idx = addr_q[15:8];
			default: idx = addr_q[7:0];
		endcase
	end

	assign grp_m1    = child_q - 1'b1;
	assign base      = {grp_m1[GRP_IDX_W-1:0], idx};
	assign child_cur = (level_q == 2'd0) ? root_q : rd_entry.child;
	assign pool_full = (free_q >= GRP_W'(GROUP_COUNT));
	assign free_inc  = free_q + 1'b1;
	assign clk_sweep_done = (clr_q == 8'hFF);

	always_comb begin
		link_entry       = rd_entry;
		link_entry.child = free_inc;
	end

	// next state and RAM port control
	always_comb begin
		state_d     = state_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = exp_addr_s1;
		ram_wr_data = '0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = base;

		// read-modify-write tail of the expansion
		if (exp_s1 && (rem4 > rd_entry.depth)) begin
			ram_wr_en         = 1'b1;
			ram_wr_data.valid = 1'b1;
			ram_wr_data.depth = rem4;
			ram_wr_data.child = rd_entry.child;
			ram_wr_data.hop   = hop_q;
		end

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = len_bad ? S_FIN : S_LEVEL;
				end
			end
			S_LEVEL: begin
				if (child_cur == '0) begin
					if (pool_full) begin
						state_d = S_FIN;
					end else begin
						state_d = S_CLEAR;
						if (level_q != 2'd0) begin
							ram_wr_en   = 1'b1;
							ram_wr_addr = parent_addr_q;
							ram_wr_data = link_entry;
						end
					end
				end else begin
					state_d = S_DESC;
				end
			end
			S_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = {grp_m1[GRP_IDX_W-1:0], clr_q};
				ram_wr_data = '0;
				if (clk_sweep_done) begin
					state_d = S_DESC;
				end
			end
			S_DESC: begin
				if (last_level) begin
					state_d = S_EXP;
				end else begin
					ram_rd_en = 1'b1;
					state_d   = S_LEVEL;
				end
			end
			S_EXP: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = {grp_m1[GRP_IDX_W-1:0], idx | k_q};
				if (k_q == exp_last_k) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			root_q      <= '0;
			free_q      <= '0;
			exp_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			exp_s1  <= (state_q == S_EXP);
			if (state_q == S_LEVEL && child_cur == '0 && !pool_full) begin
				free_q <= free_inc;
				if (level_q == 2'd0) begin
					root_q <= free_inc;
				end
			end
			if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		exp_addr_s1 <= ram_rd_addr;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					addr_q   <= in_data.route_addr & in_mask;
					len_q    <= in_data.prefix_len;
					hop_q    <= in_data.hop_value;
					level_q  <= 2'd0;
					status_q <= len_bad ? ST_BAD_LEN : ST_OK;
				end
			end
			S_LEVEL: begin
				if (child_cur == '0) begin
					if (pool_full) begin
						status_q <= ST_POOL_EMPTY;
					end else begin
						child_q <= free_inc;
						clr_q   <= 8'd0;
					end
				end else begin
					child_q <= child_cur;
				end
			end
			S_CLEAR: begin
				clr_q <= clr_q + 8'd1;
			end
			S_DESC: begin
				if (last_level) begin
					k_q <= 8'd0;
				end else begin
					parent_addr_q <= base;
					level_q       <= level_q + 2'd1;
				end
			end
			S_EXP: begin
				k_q <= k_q + 8'd1;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_q.status        <= status_q;
					out_q.groups_in_use <= 9'(free_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/lmti_checker.sv =====
// Port-level checks for the route insert unit, bound to the top level.
module lmti_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input lmti_pkg::ins_req_t in_data,
	input logic               out_valid,
	input logic               out_ready,
	input lmti_pkg::ins_rsp_t out_data
);
	import lmti_pkg::*;

	logic [8:0] last_groups_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_groups_q <= '0;
		end else if (out_valid && out_ready) begin
			last_groups_q <= out_data.groups_in_use;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one insert at a time: busy right after a transfer in
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an insert is in progress");

	// groups are never freed
	a_groups_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (GROUP_COUNT > 511) || (out_data.groups_in_use >= last_groups_q))
		else $error("groups in use went down");

	// a rejected length allocates nothing
	a_bad_len_no_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_BAD_LEN) |->
			(out_data.groups_in_use == last_groups_q))
		else $error("bad length changed the group count");

	a_groups_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(out_data.groups_in_use) <= GROUP_COUNT))
		else $error("groups in use above pool size");

endmodule

bind lpm_multibit_trie_insert_unit lmti_checker u_lmti_checker (.*);
